// ===== rtl/mbpm_pkg.sv =====
// Shared constants, types and register indexes for the masked byte pattern matcher.
package mbpm_pkg;

    localparam int NUM_PATTERNS      = 2;
    localparam int MAX_PATTERN_BYTES = 8;
    localparam int REG_SLOTS         = 2;

    localparam int BYTE_W    = 8;
    localparam int WIN_W     = 64;
    localparam int LEN_W     = 4;
    localparam int LIMIT_W   = 9;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int CELL_IDX_W = 3;
    localparam int WIN_BYTES = WIN_W / BYTE_W;

    localparam logic [LIMIT_W-1:0] LIMIT_MARGIN  = LIMIT_W'(2);
    localparam logic [LIMIT_W-1:0] MAX_THRESHOLD = LIMIT_W'(254);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(64);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_P0_VALUE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_P0_MASK   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_P0_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_P1_VALUE  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_P1_MASK   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_P1_LENGTH = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_BUF_LIMIT = CFG_IDX_W'(6);

    // One pattern as seen by the cells; length already clamped
    typedef struct packed {
        logic [WIN_W-1:0] value;
        logic [WIN_W-1:0] mask;
        logic [LEN_W-1:0] len;
    } pat_cfg_t;

    // Fill count clear control
    typedef struct packed {
        logic             clr_always;
        logic [CNT_W-1:0] threshold;
    } cnt_ctrl_t;

endpackage

// ===== rtl/mbpm_if.sv =====
// Handshake channel interfaces: input byte, result and configuration write.
interface mbpm_in_if
    import mbpm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbpm_out_if
    import mbpm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             matched;
    logic             pattern_index;
    logic [WIN_W-1:0] matched_bytes;

    modport source (output valid, output matched, output pattern_index,
                    output matched_bytes, input ready);
    modport sink   (input valid, input matched, input pattern_index,
                    input matched_bytes, output ready);
endinterface

interface mbpm_cfg_if
    import mbpm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mbpm_cfg.sv =====
// Configuration register file: pattern values, masks, lengths and buffer limit.
module mbpm_cfg
    import mbpm_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    mbpm_cfg_if.sink                         cfg,
    output pat_cfg_t [NUM_PATTERNS-1:0]      pat,
    output cnt_ctrl_t                        ctrl
);

    logic [WIN_W-1:0]   value_reg [REG_SLOTS];
    logic [WIN_W-1:0]   mask_reg  [REG_SLOTS];
    logic [LEN_W-1:0]   len_reg   [REG_SLOTS];
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] thr_raw;

    assign cfg.ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < REG_SLOTS; s++)
            begin
                value_reg[s] <= '0;
                mask_reg[s]  <= '0;
                len_reg[s]   <= '0;
            end
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_P0_VALUE:  value_reg[0] <= cfg.data;
                REG_P0_MASK:   mask_reg[0]  <= cfg.data;
                REG_P0_LENGTH: len_reg[0]   <= cfg.data[LEN_W-1:0];
                REG_P1_VALUE:  value_reg[1] <= cfg.data;
                REG_P1_MASK:   mask_reg[1]  <= cfg.data;
                REG_P1_LENGTH: len_reg[1]   <= cfg.data[LEN_W-1:0];
                REG_BUF_LIMIT: limit_reg    <= cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern view with saturated length
    always_comb
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            pat[p].value = value_reg[p];
            pat[p].mask  = mask_reg[p];
            pat[p].len   = (len_reg[p] > LEN_W'(MAX_PATTERN_BYTES)) ?
                           LEN_W'(MAX_PATTERN_BYTES) : len_reg[p];
        end
    end

    // Clear threshold: limit minus two, saturated at 254
    assign thr_raw         = limit_reg - LIMIT_MARGIN;
    assign ctrl.clr_always = (limit_reg < LIMIT_MARGIN);
    assign ctrl.threshold  = (thr_raw > MAX_THRESHOLD) ? MAX_THRESHOLD[CNT_W-1:0]
                                                       : thr_raw[CNT_W-1:0];

endmodule

// ===== rtl/mbpm_cell.sv =====
// Window cell: holds one byte; checks its input against every pattern.
module mbpm_cell
    import mbpm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic [CELL_IDX_W-1:0]         cell_idx,
    input  logic [BYTE_W-1:0]             byte_in,
    input  pat_cfg_t [NUM_PATTERNS-1:0]   pat,
    output logic [BYTE_W-1:0]             byte_out,
    output logic [NUM_PATTERNS-1:0]       hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  pos_full [NUM_PATTERNS];
    logic [CELL_IDX_W-1:0] pos  [NUM_PATTERNS];
    logic [BYTE_W-1:0] val_b    [NUM_PATTERNS];
    logic [BYTE_W-1:0] msk_b    [NUM_PATTERNS];
    logic              used     [NUM_PATTERNS];

    // Byte storage, shifts toward older cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else if (shift_en)
            byte_reg <= byte_in;
    end

    assign byte_out = byte_reg;

    // Compare the byte arriving now; this cell is pattern byte len-1-age
    always_comb
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            used[p]     = ({1'b0, cell_idx} < pat[p].len);
            pos_full[p] = pat[p].len - LEN_W'(1) - {1'b0, cell_idx};
            pos[p]      = pos_full[p][CELL_IDX_W-1:0];
            val_b[p]    = pat[p].value[pos[p]*BYTE_W +: BYTE_W];
            msk_b[p]    = pat[p].mask[pos[p]*BYTE_W +: BYTE_W];
            hit[p]      = !used[p] || (((byte_in ^ val_b[p]) & msk_b[p]) == '0);
        end
    end

endmodule

// ===== rtl/masked_byte_pattern_matcher_core.sv =====
// Top level: cell chain, fill count, pattern priority and result register.
//
//  channel | dir | fields                                  | handshake
//  in_ch   | in  | rx_byte[7:0]                            | valid/ready
//  out_ch  | out | matched, pattern_index, matched_bytes   | valid/ready
//  cfg     | in  | index[2:0], data[63:0]                  | valid/ready
//
// One item per cycle unless the output stalls; each result is registered in
// the cycle its byte is taken. The cell chain shift, all masked compares and
// the count update share it; the result register decouples the output side.
// Input ready is high while the result register is empty or being drained.
// Reset zeroes the window, fill count, result and pattern regs; limit is 64.
module masked_byte_pattern_matcher_core
    import mbpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mbpm_in_if.sink      in_ch,
    mbpm_out_if.source   out_ch,
    mbpm_cfg_if.sink     cfg
);

    pat_cfg_t [NUM_PATTERNS-1:0]    pat;
    cnt_ctrl_t                      ctrl;
    logic [BYTE_W-1:0]              cell_in   [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0]              cell_out  [MAX_PATTERN_BYTES];
    logic [NUM_PATTERNS-1:0]        cell_hit  [MAX_PATTERN_BYTES];
    logic [NUM_PATTERNS-1:0]        pat_hit;
    logic                           in_fire;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [CNT_W-1:0]               count_base;
    logic [CNT_W-1:0]               count_inc;
    logic                           match_w;
    logic                           win_idx;
    logic [LEN_W-1:0]               win_len;
    logic [WIN_W-1:0]               win_bytes;
    logic [LEN_W-1:0]               src_full;
    logic                           out_valid_reg;
    logic                           matched_reg;
    logic                           index_reg;
    logic [WIN_W-1:0]               bytes_reg;

    mbpm_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pat   (pat),
        .ctrl  (ctrl)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Cell chain, newest byte in cell 0
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN_BYTES; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign cell_in[k] = in_ch.rx_byte;
            end
            else
            begin : g_link
                assign cell_in[k] = cell_out[k-1];
            end

            mbpm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (in_fire),
                .cell_idx (CELL_IDX_W'(k)),
                .byte_in  (cell_in[k]),
                .pat      (pat),
                .byte_out (cell_out[k]),
                .hit      (cell_hit[k])
            );
        end
    endgenerate

    // Fill count after the optional clear and the new byte
    assign count_base = (ctrl.clr_always || (count_reg > ctrl.threshold)) ? '0 : count_reg;
    assign count_inc  = count_base + CNT_W'(1);

    // Per pattern match, lowest index first
    always_comb
    begin
        match_w = 1'b0;
        win_idx = 1'b0;
        win_len = '0;
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            pat_hit[p] = (pat[p].len != '0) && (count_inc >= CNT_W'(pat[p].len));
            for (int c = 0; c < MAX_PATTERN_BYTES; c++)
                pat_hit[p] = pat_hit[p] && cell_hit[c][p];
        end
        for (int p = NUM_PATTERNS - 1; p >= 0; p--)
        begin
            if (pat_hit[p])
            begin
                match_w = 1'b1;
                win_idx = 1'(p);
                win_len = pat[p].len;
            end
        end
    end

    // Matched window, oldest byte first, upper bytes zero
    always_comb
    begin
        win_bytes = '0;
        src_full  = '0;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            src_full = win_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < win_len)
                win_bytes[j*BYTE_W +: BYTE_W] = cell_in[src_full[CELL_IDX_W-1:0]];
        end
    end

    assign count_next = match_w ? '0 : count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_fire)
            count_reg <= count_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 1'b0;
            index_reg   <= 1'b0;
            bytes_reg   <= '0;
        end
        else if (in_fire)
        begin
            matched_reg <= match_w;
            index_reg   <= win_idx;
            bytes_reg   <= win_bytes;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.matched       = matched_reg;
    assign out_ch.pattern_index = index_reg;
    assign out_ch.matched_bytes = bytes_reg;

`ifndef ASSERT_OFF
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !matched_reg) |-> (!index_reg && bytes_reg == '0))
        else $error("non-match result carries data");

    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && match_w) |=> (count_reg == '0))
        else $error("fill count not cleared on match");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !match_w) |=> (count_reg != '0))
        else $error("fill count zero after unmatched byte");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the masked byte pattern matcher core.
module tb
    import mbpm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic             matched;
        logic             pattern_index;
        logic [WIN_W-1:0] matched_bytes;
    } match_t;

    logic clk = 1'b0;
    logic rst_n;

    mbpm_in_if  in_ch ();
    mbpm_out_if out_ch ();
    mbpm_cfg_if cfg_ch ();

    masked_byte_pattern_matcher_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // Matcher state and register copy
    logic [WIN_W-1:0]   pat_val [NUM_PATTERNS] = '{default: '0};
    logic [WIN_W-1:0]   pat_msk [NUM_PATTERNS] = '{default: '0};
    logic [LEN_W-1:0]   pat_len [NUM_PATTERNS] = '{default: '0};
    logic [LIMIT_W-1:0] buf_limit = LIMIT_RESET;
    logic [WIN_W-1:0]   recent = '0;
    logic [CNT_W-1:0]   fill_cnt = '0;

    match_t expected_results [$];
    match_t head_result;
    int     err_count = 0;
    int     cycles = 0;
    int     src_idle_pct;
    int     sink_idle_pct;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("[masked_byte_pattern_matcher_core] ERROR");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Compare each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", out_ch.matched_bytes, '0);
            else
            begin
                head_result = expected_results.pop_front();
                if (out_ch.matched !== head_result.matched)
                    report_mismatch("matched", 64'(out_ch.matched),
                                    64'(head_result.matched));
                if (out_ch.pattern_index !== head_result.pattern_index)
                    report_mismatch("pattern_index", 64'(out_ch.pattern_index),
                                    64'(head_result.pattern_index));
                if (out_ch.matched_bytes !== head_result.matched_bytes)
                    report_mismatch("matched_bytes", out_ch.matched_bytes,
                                    head_result.matched_bytes);
            end
        end
    end

    // Pattern length with oversize lengths clamped
    function automatic int eff_len(input int p);
        return (pat_len[p] > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len[p]);
    endfunction

    // Take one byte into the window and find the first matching pattern
    function automatic match_t scan_byte(input logic [BYTE_W-1:0] b);
        match_t             r;
        logic               clr;
        logic [LIMIT_W-1:0] thr;
        logic [WIN_W-1:0]   w;
        logic [WIN_W-1:0]   lanes;
        logic               found;
        int                 p;
        int                 j;
        int                 n;
        r = '0;
        found = 1'b0;
        if (buf_limit < LIMIT_MARGIN)
            clr = 1'b1;
        else
        begin
            thr = buf_limit - LIMIT_MARGIN;
            if (thr > MAX_THRESHOLD)
                thr = MAX_THRESHOLD;
            clr = ({1'b0, fill_cnt} > thr);
        end
        if (clr)
            fill_cnt = '0;
        recent = {recent[WIN_W-BYTE_W-1:0], b};
        fill_cnt = fill_cnt + CNT_W'(1);
        for (p = 0; p < NUM_PATTERNS; p++)
        begin
            n = eff_len(p);
            if (!found && n != 0 && int'(fill_cnt) >= n)
            begin
                w = '0;
                for (j = 0; j < n; j++)
                    w[8*j +: 8] = recent[8*(n-1-j) +: 8];
                lanes = (n >= WIN_BYTES) ? '1 : ((64'd1 << (8*n)) - 64'd1);
                if (((w ^ pat_val[p]) & pat_msk[p] & lanes) == '0)
                begin
                    r.matched = 1'b1;
                    r.pattern_index = p[0];
                    r.matched_bytes = w;
                    fill_cnt = '0;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Send one byte, with a random gap in front
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.push_back(scan_byte(b));
    endtask

    // Stop sending and let every pending result drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_P0_VALUE:  pat_val[0] = d;
            REG_P0_MASK:   pat_msk[0] = d;
            REG_P0_LENGTH: pat_len[0] = d[LEN_W-1:0];
            REG_P1_VALUE:  pat_val[1] = d;
            REG_P1_MASK:   pat_msk[1] = d;
            REG_P1_LENGTH: pat_len[1] = d[LEN_W-1:0];
            REG_BUF_LIMIT: buf_limit = d[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Write every register, plus a junk write to the unused index
    task automatic load_patterns(input logic [63:0] v0, input logic [63:0] m0,
                                 input logic [63:0] l0, input logic [63:0] v1,
                                 input logic [63:0] m1, input logic [63:0] l1,
                                 input logic [63:0] lim);
        write_reg(REG_P0_VALUE, v0);
        write_reg(REG_P0_MASK, m0);
        write_reg(REG_P0_LENGTH, l0);
        write_reg(REG_P1_VALUE, v1);
        write_reg(REG_P1_MASK, m1);
        write_reg(REG_P1_LENGTH, l1);
        write_reg(REG_BUF_LIMIT, lim);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [WIN_W-1:0]   msk [NUM_PATTERNS];
        logic [LEN_W-1:0]   len [NUM_PATTERNS];
        logic [LIMIT_W-1:0] lim;
        int                 p;
        int                 j;
        for (p = 0; p < NUM_PATTERNS; p++)
        begin
            case ($urandom_range(9))
                0:       len[p] = '0;
                1:       len[p] = LEN_W'($urandom_range(15, 9));
                2:       len[p] = LEN_W'(MAX_PATTERN_BYTES);
                default: len[p] = LEN_W'($urandom_range(MAX_PATTERN_BYTES, 1));
            endcase
            case ($urandom_range(4))
                0, 1: msk[p] = '1;
                2:    msk[p] = '0;
                default:
                begin
                    for (j = 0; j < WIN_BYTES; j++)
                    begin
                        case ($urandom_range(2))
                            0:       msk[p][8*j +: 8] = 8'hFF;
                            1:       msk[p][8*j +: 8] = 8'h00;
                            default: msk[p][8*j +: 8] = 8'($urandom);
                        endcase
                    end
                end
            endcase
        end
        case ($urandom_range(9))
            0:       lim = LIMIT_W'($urandom_range(1));
            1:       lim = LIMIT_W'(2);
            2:       lim = LIMIT_W'(3);
            3:       lim = LIMIT_W'($urandom_range(511, 257));
            4:       lim = LIMIT_W'(256);
            5:       lim = LIMIT_RESET;
            default: lim = LIMIT_W'($urandom_range(40, 4));
        endcase
        load_patterns({$urandom, $urandom}, msk[0], {$urandom, 28'($urandom), len[0]},
                      {$urandom, $urandom}, msk[1], {$urandom, 28'($urandom), len[1]},
                      {$urandom, 23'($urandom), lim});
    endtask

    // Mostly masked pattern frames with random don't-care bits, some noise
    task automatic send_traffic(input int count);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] mb;
        int                sent;
        int                p;
        int                n;
        int                j;
        sent = 0;
        while (sent < count)
        begin
            p = $urandom_range(1);
            if (eff_len(p) == 0)
                p = 1 - p;
            n = eff_len(p);
            if ($urandom_range(99) < 70 && n > 0)
            begin
                repeat ($urandom_range(3))
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
                for (j = 0; j < n; j++)
                begin
                    mb = pat_msk[p][8*j +: 8];
                    b = (pat_val[p][8*j +: 8] & mb) | (8'($urandom) & ~mb);
                    // occasionally break the frame
                    if ($urandom_range(9) == 0)
                        b = b ^ (8'd1 << $urandom_range(7));
                    send_byte(b);
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_byte(8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // Registers at reset values: all patterns off
    task automatic test_reset_state();
        send_byte(8'h5A);
        send_byte(8'hA5);
        wait_idle();
    endtask

    task automatic test_directed_patterns();
        logic [63:0] seq;
        int          j;
        seq = 64'h0123_4567_89AB_CDEF;
        // full eight-byte compare vs. oversize length with empty mask, limit above 256
        load_patterns(seq, '1, {60'hABC, 4'd8}, {$urandom, $urandom}, '0, 64'hF, '1);
        // fillers bring the count to eight: the mask-free pattern fires and clears it
        for (j = 0; j < 6; j++)
            send_byte(8'h00);
        // both patterns hit on the eighth byte; lower index wins
        for (j = 0; j < 8; j++)
            send_byte(seq[8*j +: 8]);
        // only the oversize pattern hits
        for (j = 0; j < 8; j++)
            send_byte(j[0] ? 8'hFF : 8'h00);
        wait_idle();
        // limit of zero: count always one, two-byte pattern never fires
        load_patterns(64'h00, 64'hFF, 64'h1, '1, '0, 64'h2, 64'h0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
        load_patterns(64'h00, 64'hFF, 64'h1, '1, '0, 64'h2, 64'h1);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
        // limit of three: count clears before reaching three
        load_patterns('0, '0, 64'h0, '0, '0, 64'h3, 64'h3);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
    endtask

    // Several random configurations under one idle mix
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (4)
        begin
            wait_idle();
            random_config();
            send_traffic(count / 4);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        src_idle_pct = 38;
        sink_idle_pct = 52;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_patterns();
        test_random_traffic(38, 52, 470);
        test_random_traffic(52, 38, 470);
        test_random_traffic(0, 0, 470);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("[masked_byte_pattern_matcher_core] OK");
        else
            $display("[masked_byte_pattern_matcher_core] ERROR");
        $finish;
    end

endmodule

// ===== masked_byte_pattern_matcher_core.f =====
rtl/mbpm_pkg.sv
rtl/mbpm_if.sv
rtl/mbpm_cfg.sv
rtl/mbpm_cell.sv
rtl/masked_byte_pattern_matcher_core.sv
dv/tb.sv
